// ===== hdl/pbcs_pkg.sv =====
// Shared types, widths and request codes for the pairwise box collision scan.
// No dependencies; every other file imports this package.
package pbcs_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int KINDS_DEF = 8;

   localparam int REQ_CODE_W   = 2;
   localparam int SLOT_FIELD_W = 3;
   localparam int COORD_W      = 16;
   localparam int SIZE_W       = 12;
   localparam int KIND_W       = 3;
   localparam int ENABLE_W     = 64;

   localparam logic [REQ_CODE_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [REQ_CODE_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_CODE_W-1:0] REQ_TICK   = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] box_x;
      logic signed [COORD_W-1:0] box_y;
      logic [SIZE_W-1:0]         box_w;
      logic [SIZE_W-1:0]         box_h;
      logic [KIND_W-1:0]         kind;
   } slot_rec_type;

   typedef struct packed {
      logic enabled;
      logic overlap;
   } pair_result_type;

endpackage

// ===== hdl/pbcs_if.sv =====
// Valid/ready channel interfaces for request, response and register-write beats.
// Depends on pbcs_pkg for field widths.
interface pbcs_req_if import pbcs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [REQ_CODE_W-1:0]     req_type;
   logic [SLOT_FIELD_W-1:0]   slot;
   logic signed [COORD_W-1:0] box_x;
   logic signed [COORD_W-1:0] box_y;
   logic [SIZE_W-1:0]         box_w;
   logic [SIZE_W-1:0]         box_h;
   logic [KIND_W-1:0]         collider_type;

   modport source (output valid, req_type, slot, box_x, box_y, box_w, box_h, collider_type,
                   input ready);
   modport sink (input valid, req_type, slot, box_x, box_y, box_w, box_h, collider_type,
                 output ready);
endinterface

interface pbcs_rsp_if import pbcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SLOT_FIELD_W-1:0] first_slot;
   logic [SLOT_FIELD_W-1:0] second_slot;
   logic                    contact_kind;
   logic                    last_event;

   modport source (output valid, first_slot, second_slot, contact_kind, last_event,
                   input ready);
   modport sink (input valid, first_slot, second_slot, contact_kind, last_event,
                 output ready);
endinterface

interface pbcs_csr_if import pbcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ENABLE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hdl/pbcs_slot_table.sv =====
// Collider slot table: box and type memory with two registered read ports,
// plus per-slot valid flags. Depends on pbcs_pkg.
module pbcs_slot_table import pbcs_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic                     clr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_slot,
   input  slot_rec_type             wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(SLOTS)-1:0] rd_slot_a,
   input  logic [$clog2(SLOTS)-1:0] rd_slot_b,
   output slot_rec_type             rd_rec_a,
   output slot_rec_type             rd_rec_b,
   output logic                     rd_valid_a,
   output logic                     rd_valid_b
);

   slot_rec_type       slot_mem_ff [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   valid_in;
   slot_rec_type       rd_rec_a_ff;
   slot_rec_type       rd_rec_b_ff;
   logic               rd_valid_a_ff;
   logic               rd_valid_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_slot] = 1'b1;
      end else if (clr_en) begin
         valid_in[wr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_rec_a_ff   <= slot_mem_ff[rd_slot_a];
         rd_rec_b_ff   <= slot_mem_ff[rd_slot_b];
         rd_valid_a_ff <= valid_ff[rd_slot_a];
         rd_valid_b_ff <= valid_ff[rd_slot_b];
      end
   end

   assign rd_rec_a   = rd_rec_a_ff;
   assign rd_rec_b   = rd_rec_b_ff;
   assign rd_valid_a = rd_valid_a_ff;
   assign rd_valid_b = rd_valid_b_ff;

endmodule

// ===== hdl/pbcs_pair_check.sv =====
// Shared pair unit: type-matrix enable lookup and axis-aligned overlap compare
// for one slot pair per cycle. Depends on pbcs_pkg.
module pbcs_pair_check import pbcs_pkg::*; #(
   parameter int KINDS = KINDS_DEF
) (
   input  slot_rec_type        rec_a,
   input  slot_rec_type        rec_b,
   input  logic [ENABLE_W-1:0] enable_mask,
   output pair_result_type     result
);

   localparam int EXT_W = COORD_W + 2;
   localparam int BIT_W = 2 * KIND_W + 1;

   logic signed [EXT_W-1:0] ax;
   logic signed [EXT_W-1:0] ay;
   logic signed [EXT_W-1:0] bx;
   logic signed [EXT_W-1:0] by;
   logic signed [EXT_W-1:0] ax_end;
   logic signed [EXT_W-1:0] ay_end;
   logic signed [EXT_W-1:0] bx_end;
   logic signed [EXT_W-1:0] by_end;
   logic                    nonempty;
   logic [BIT_W-1:0]        bit_idx;
   logic                    kinds_ok;

   always_comb begin
      ax = EXT_W'(rec_a.box_x);
      ay = EXT_W'(rec_a.box_y);
      bx = EXT_W'(rec_b.box_x);
      by = EXT_W'(rec_b.box_y);
      ax_end = ax + $signed({{(EXT_W - SIZE_W){1'b0}}, rec_a.box_w});
      ay_end = ay + $signed({{(EXT_W - SIZE_W){1'b0}}, rec_a.box_h});
      bx_end = bx + $signed({{(EXT_W - SIZE_W){1'b0}}, rec_b.box_w});
      by_end = by + $signed({{(EXT_W - SIZE_W){1'b0}}, rec_b.box_h});
      nonempty = (rec_a.box_w != '0) && (rec_a.box_h != '0) &&
                 (rec_b.box_w != '0) && (rec_b.box_h != '0);
      result.overlap = nonempty && (ax < bx_end) && (bx < ax_end) &&
                       (ay < by_end) && (by < ay_end);

      kinds_ok = (32'(rec_a.kind) < KINDS) && (32'(rec_b.kind) < KINDS);
      bit_idx  = BIT_W'(rec_a.kind) * BIT_W'(KINDS) + BIT_W'(rec_b.kind);
      result.enabled = kinds_ok && (bit_idx < BIT_W'(ENABLE_W)) &&
                       enable_mask[bit_idx[$clog2(ENABLE_W)-1:0]];
   end

endmodule

// ===== hdl/pairwise_box_collision_scan.sv =====
// Pairwise box collision scan, top level. A tick walks SLOTS*(SLOTS-1)/2 slot pairs
// through one shared compare unit, one pair per cycle, then returns to idle; a stalled
// result channel holds the walk. Requests are refused during a tick.
// Reset clears the enable matrix, slot valid flags and all pair contact state.
// Depends on pbcs_pkg, pbcs_if, pbcs_slot_table and pbcs_pair_check.
module pairwise_box_collision_scan import pbcs_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int KINDS = KINDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pbcs_csr_if.sink   csr_ch,
   pbcs_req_if.sink   req_ch,
   pbcs_rsp_if.source rsp_ch
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int PAIRS  = SLOTS * SLOTS;
   localparam int PAIR_W = $clog2(PAIRS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [SLOT_W-1:0]       fi_ff, fi_in;
   logic [SLOT_W-1:0]       fj_ff, fj_in;
   logic                    fetch_more_ff, fetch_more_in;
   logic                    e_valid_ff, e_valid_in;
   logic [SLOT_W-1:0]       e_i_ff, e_i_in;
   logic [SLOT_W-1:0]       e_j_ff, e_j_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]       pend_i_ff, pend_i_in;
   logic [SLOT_W-1:0]       pend_j_ff, pend_j_in;
   logic                    pend_kind_ff, pend_kind_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SLOT_FIELD_W-1:0] out_first_ff, out_first_in;
   logic [SLOT_FIELD_W-1:0] out_second_ff, out_second_in;
   logic                    out_kind_ff, out_kind_in;
   logic                    out_last_ff, out_last_in;
   logic [PAIRS-1:0]        touch_ff, touch_in;
   logic [ENABLE_W-1:0]     enable_ff, enable_in;

   logic              req_acc;
   logic              slot_ok;
   logic [SLOT_W-1:0] req_slot;
   logic              tbl_wr;
   logic              tbl_clr;
   logic              tbl_rd;
   slot_rec_type      wr_rec;
   slot_rec_type      rec_a;
   slot_rec_type      rec_b;
   logic              valid_a;
   logic              valid_b;
   pair_result_type   chk;
   logic [PAIR_W-1:0] e_idx;
   logic              out_busy;
   logic              upd;
   logic              hit;
   logic              stall;
   logic              last_pair;
   logic              row_end;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign slot_ok      = (32'(req_ch.slot) < SLOTS);
   assign req_slot     = SLOT_W'(req_ch.slot);
   assign tbl_wr       = req_acc && (req_ch.req_type == REQ_WRITE) && slot_ok;
   assign tbl_clr      = req_acc && (req_ch.req_type == REQ_REMOVE) && slot_ok;

   assign wr_rec.box_x = req_ch.box_x;
   assign wr_rec.box_y = req_ch.box_y;
   assign wr_rec.box_w = req_ch.box_w;
   assign wr_rec.box_h = req_ch.box_h;
   assign wr_rec.kind  = req_ch.collider_type;

   assign out_busy  = out_valid_ff && !rsp_ch.ready;
   assign e_idx     = PAIR_W'(32'(e_i_ff) * SLOTS + 32'(e_j_ff));
   assign upd       = e_valid_ff && valid_a && valid_b && chk.enabled;
   assign hit       = upd && chk.overlap;
   assign stall     = hit && pend_valid_ff && out_busy;
   assign tbl_rd    = (state_ff == ST_SCAN) && !stall && fetch_more_ff;
   assign row_end   = (fj_ff == SLOT_W'(SLOTS - 1));
   assign last_pair = row_end && (fi_ff == SLOT_W'(SLOTS - 2));

   pbcs_slot_table #(
      .SLOTS(SLOTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (tbl_wr),
      .clr_en     (tbl_clr),
      .wr_slot    (req_slot),
      .wr_data    (wr_rec),
      .rd_en      (tbl_rd),
      .rd_slot_a  (fi_ff),
      .rd_slot_b  (fj_ff),
      .rd_rec_a   (rec_a),
      .rd_rec_b   (rec_b),
      .rd_valid_a (valid_a),
      .rd_valid_b (valid_b)
   );

   pbcs_pair_check #(
      .KINDS(KINDS)
   ) u_check (
      .rec_a       (rec_a),
      .rec_b       (rec_b),
      .enable_mask (enable_ff),
      .result      (chk)
   );

   always_comb begin
      state_in      = state_ff;
      fi_in         = fi_ff;
      fj_in         = fj_ff;
      fetch_more_in = fetch_more_ff;
      e_valid_in    = e_valid_ff;
      e_i_in        = e_i_ff;
      e_j_in        = e_j_ff;
      pend_valid_in = pend_valid_ff;
      pend_i_in     = pend_i_ff;
      pend_j_in     = pend_j_ff;
      pend_kind_in  = pend_kind_ff;
      out_valid_in  = out_valid_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_kind_in   = out_kind_ff;
      out_last_in   = out_last_ff;
      touch_in      = touch_ff;
      enable_in     = enable_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         enable_in = csr_ch.data;
      end
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (tbl_wr || tbl_clr) begin
               for (int r = 0; r < SLOTS; r++) begin
                  for (int c = 0; c < SLOTS; c++) begin
                     if (r == int'(req_slot) || c == int'(req_slot)) begin
                        touch_in[r * SLOTS + c] = 1'b0;
                     end
                  end
               end
            end
            if (req_acc && req_ch.req_type == REQ_TICK) begin
               state_in      = ST_SCAN;
               fi_in         = '0;
               fj_in         = SLOT_W'(1);
               fetch_more_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (upd) begin
                  touch_in[e_idx] = chk.overlap;
               end
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_first_in  = SLOT_FIELD_W'(pend_i_ff);
                     out_second_in = SLOT_FIELD_W'(pend_j_ff);
                     out_kind_in   = pend_kind_ff;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_i_in     = e_i_ff;
                  pend_j_in     = e_j_ff;
                  pend_kind_in  = touch_ff[e_idx];
               end
               e_valid_in = fetch_more_ff;
               e_i_in     = fi_ff;
               e_j_in     = fj_ff;
               if (fetch_more_ff) begin
                  if (last_pair) begin
                     fetch_more_in = 1'b0;
                  end else if (row_end) begin
                     fi_in = fi_ff + SLOT_W'(1);
                     fj_in = fi_ff + SLOT_W'(2);
                  end else begin
                     fj_in = fj_ff + SLOT_W'(1);
                  end
               end
               if (!fetch_more_ff && !e_valid_ff) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!out_busy) begin
               out_valid_in  = 1'b1;
               out_first_in  = SLOT_FIELD_W'(pend_i_ff);
               out_second_in = SLOT_FIELD_W'(pend_j_ff);
               out_kind_in   = pend_kind_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fetch_more_ff <= 1'b0;
         e_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         touch_ff      <= '0;
         enable_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         fetch_more_ff <= fetch_more_in;
         e_valid_ff    <= e_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         touch_ff      <= touch_in;
         enable_ff     <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      fi_ff         <= fi_in;
      fj_ff         <= fj_in;
      e_i_ff        <= e_i_in;
      e_j_ff        <= e_j_in;
      pend_i_ff     <= pend_i_in;
      pend_j_ff     <= pend_j_in;
      pend_kind_ff  <= pend_kind_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_kind_ff   <= out_kind_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.first_slot   = out_first_ff;
   assign rsp_ch.second_slot  = out_second_ff;
   assign rsp_ch.contact_kind = out_kind_ff;
   assign rsp_ch.last_event   = out_last_ff;

endmodule
